@@ design/rmv_pkg.sv @@
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared types and constants for the running mean / variance block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmv_pkg;

  // field widths
  localparam int SAMPLE_W = 32;
  localparam int FRAC_W   = 16;
  localparam int COUNT_W  = 32;
  localparam int ABS_W    = SAMPLE_W - 1;
  localparam int SQ_W     = 64;
  localparam int DD_W     = 2 * SAMPLE_W - FRAC_W;
  localparam int VAR_W    = 48;
  localparam int SIGMA_W  = 32;

  // serial unit sizing
  localparam int DIV_W    = 64;
  localparam int STEP_W   = 7;
  localparam int SQR_W    = 2 * SAMPLE_W;
  localparam int SQRT_W   = 64;

  // configuration register indexes
  localparam logic CFG_SKIP_MISSING   = 1'b0;
  localparam logic CFG_MISSING_MARKER = 1'b1;

  // status of a bit-serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQR,
    ST_DMEAN,
    ST_DSQ,
    ST_DABS,
    ST_VAR_GO,
    ST_DVAR,
    ST_SQRT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ design/running_mean_variance_top.sv @@
// ----------------------------------------------------------------------------
// running_mean_variance_top
// Welford running count, mean, absolute mean, variance and standard
// deviation over a stream of signed Q16.16 samples.
// ----------------------------------------------------------------------------
// One sample is taken at a time and each gives one result beat. An accepted
// sample goes through a check step, a serial square, three passes through
// the shared bit-serial divider, a variance division and a square root,
// then a hand-over to the result register. A skipped sample or the first
// sample of a run goes through fewer steps. The next sample is taken while
// the previous result still waits on the master side.
`default_nettype none

module running_mean_variance_top
  import rmv_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [31:0]  cfg_wdata,
  // sample input
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,   // sample_value
  input  wire logic         s_tuser,   // restart
  // result output
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // sample_count, running_mean, running_abs_mean, sample_variance,
  // std_deviation, one pad bit
  output logic [175:0]      m_tdata,
  output logic [1:0]        m_tuser    // variance_valid, was_skipped
);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [ABS_W-1:0]   ABS_MAX   = '1;

  state_t state, state_next;

  // configuration registers
  logic                skip_missing;
  logic [SAMPLE_W-1:0] missing_marker;

  // statistics
  logic [COUNT_W-1:0]  count;
  logic [SAMPLE_W-1:0] mean;
  logic [ABS_W-1:0]    abs_mean;
  logic [SQ_W-1:0]     sq_sum;

  // per-item working registers
  logic [SAMPLE_W-1:0] sample;
  logic                skipped;
  logic [SAMPLE_W-1:0] dmag;
  logic                dneg;
  logic                aneg;
  logic [VAR_W-1:0]    variance;
  logic [SIGMA_W-1:0]  sigma;
  logic                var_valid;

  // serial units
  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [COUNT_W-1:0]  div_divisor;
  logic [STEP_W-1:0]   div_steps;
  logic [DIV_W-1:0]    div_quot;
  logic [COUNT_W-1:0]  div_rem;
  unit_stat_t          div_stat;
  logic                sqr_start;
  logic [SQR_W-1:0]    sqr_prod;
  unit_stat_t          sqr_stat;
  logic                sqrt_start;
  logic [SQRT_W-1:0]   sqrt_rad;
  logic [SIGMA_W-1:0]  sqrt_root;
  unit_stat_t          sqrt_stat;

  // combinational datapath
  logic [SAMPLE_W:0]   d_full;
  logic [SAMPLE_W-1:0] d_mag;
  logic [ABS_W-1:0]    abs_x;
  logic [ABS_W:0]      a_full;
  logic [ABS_W-1:0]    a_mag;
  logic [DD_W-1:0]     dd;
  logic [DD_W-1:0]     q_ceil;
  logic [DD_W-1:0]     inc;
  logic [SQ_W:0]       sq_add;
  logic [VAR_W-1:0]    var_sat;
  logic                out_free;

  // deviation from the mean and absolute-value deviation
  always_comb begin
    d_full = {sample[SAMPLE_W-1], sample} - {mean[SAMPLE_W-1], mean};
    d_mag  = d_full[SAMPLE_W] ? SAMPLE_W'(-d_full) : d_full[SAMPLE_W-1:0];
    if (sample[SAMPLE_W-1]) begin
      abs_x = (sample[SAMPLE_W-2:0] == '0) ? ABS_MAX : ABS_W'(-sample);
    end else begin
      abs_x = sample[ABS_W-1:0];
    end
    a_full = {1'b0, abs_x} - {1'b0, abs_mean};
    a_mag  = a_full[ABS_W] ? ABS_W'(-a_full) : a_full[ABS_W-1:0];
  end

  // squared deviation increment and variance saturation
  always_comb begin
    dd      = sqr_prod[SQR_W-1:FRAC_W];
    q_ceil  = div_quot[DD_W-1:0] + DD_W'(div_rem != '0);
    inc     = dd - q_ceil;
    sq_add  = {1'b0, sq_sum} + {{(SQ_W-DD_W+1){1'b0}}, inc};
    var_sat = (div_quot[DIV_W-1:VAR_W] != '0) ? '1 : div_quot[VAR_W-1:0];
  end

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (skipped) begin
          state_next = (count >= COUNT_W'(2)) ? ST_VAR_GO : ST_DONE;
        end else if (count == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SQR;
        end
      end
      ST_SQR:    if (sqr_stat.done) state_next = ST_DMEAN;
      ST_DMEAN:  if (div_stat.done) state_next = ST_DSQ;
      ST_DSQ:    if (div_stat.done) state_next = ST_DABS;
      ST_DABS:   if (div_stat.done) state_next = ST_VAR_GO;
      ST_VAR_GO: state_next = ST_DVAR;
      ST_DVAR:   if (div_stat.done) state_next = ST_SQRT;
      ST_SQRT:   if (sqrt_stat.done) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // unit launches and operand selection
  always_comb begin
    sqr_start    = (state == ST_CHECK) && !skipped && (count != '0);
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = count;
    div_steps    = '0;
    unique case (state)
      ST_SQR: begin
        div_start    = sqr_stat.done;
        div_dividend = {dmag, {(DIV_W-SAMPLE_W){1'b0}}};
        div_steps    = STEP_W'(SAMPLE_W);
      end
      ST_DMEAN: begin
        div_start    = div_stat.done;
        div_dividend = {dd, {(DIV_W-DD_W){1'b0}}};
        div_steps    = STEP_W'(DD_W);
      end
      ST_DSQ: begin
        div_start    = div_stat.done;
        div_dividend = {1'b0, a_mag, {(DIV_W-ABS_W-1){1'b0}}};
        div_steps    = STEP_W'(ABS_W + 1);
      end
      ST_VAR_GO: begin
        div_start    = 1'b1;
        div_dividend = sq_sum;
        div_divisor  = count - COUNT_W'(1);
        div_steps    = STEP_W'(DIV_W);
      end
      default: ;
    endcase
    sqrt_start = (state == ST_DVAR) && div_stat.done;
    sqrt_rad   = {var_sat, {(SQRT_W-VAR_W){1'b0}}};
  end

  // state register and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      skip_missing   <= 1'b0;
      missing_marker <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_SKIP_MISSING:   skip_missing   <= cfg_wdata[0];
          CFG_MISSING_MARKER: missing_marker <= cfg_wdata[SAMPLE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // statistics update
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      mean     <= '0;
      abs_mean <= '0;
      sq_sum   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tuser) begin
            count    <= '0;
            mean     <= '0;
            abs_mean <= '0;
            sq_sum   <= '0;
          end
        end
        ST_CHECK: begin
          if (!skipped) begin
            if (count != COUNT_MAX) count <= count + COUNT_W'(1);
            if (count == '0) begin
              mean     <= sample;
              abs_mean <= abs_x;
              sq_sum   <= '0;
            end
          end
        end
        ST_DMEAN: begin
          if (div_stat.done) begin
            mean <= dneg ? mean - div_quot[SAMPLE_W-1:0]
                         : mean + div_quot[SAMPLE_W-1:0];
          end
        end
        ST_DSQ: begin
          if (div_stat.done) sq_sum <= sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
        end
        ST_DABS: begin
          if (div_stat.done) begin
            abs_mean <= aneg ? abs_mean - div_quot[ABS_W-1:0]
                             : abs_mean + div_quot[ABS_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          sample  <= s_tdata[SAMPLE_W-1:0];
          skipped <= skip_missing && (s_tdata[SAMPLE_W-1:0] == missing_marker);
        end
      end
      ST_CHECK: begin
        dmag      <= d_mag;
        dneg      <= d_full[SAMPLE_W];
        variance  <= '0;
        sigma     <= '0;
        var_valid <= 1'b0;
      end
      ST_DSQ: begin
        if (div_stat.done) aneg <= a_full[ABS_W];
      end
      ST_VAR_GO: var_valid <= 1'b1;
      ST_DVAR: begin
        if (div_stat.done) variance <= var_sat;
      end
      ST_SQRT: begin
        if (sqrt_stat.done) sigma <= sqrt_root;
      end
      default: ;
    endcase
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {1'b0, sigma, variance, abs_mean, mean, count};
      m_tuser <= {skipped, var_valid};
    end
  end

  // bit-serial units
  rmv_sqr u_sqr (
    .clk     (clk),
    .rst     (rst),
    .start   (sqr_start),
    .operand (d_mag),
    .product (sqr_prod),
    .stat    (sqr_stat)
  );

  rmv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .steps     (div_steps),
    .quotient  (div_quot),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  rmv_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .root     (sqrt_root),
    .stat     (sqrt_stat)
  );

endmodule

`default_nettype wire

@@ design/rmv_div.sv @@
// ----------------------------------------------------------------------------
// rmv_div
// Restoring divider, one quotient bit per cycle. The dividend comes in
// left aligned, so a run divides its top steps bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_div
  import rmv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIV_W-1:0]     dividend,
  input  wire logic [COUNT_W-1:0]   divisor,
  input  wire logic [STEP_W-1:0]    steps,
  output logic      [DIV_W-1:0]     quotient,
  output logic      [COUNT_W-1:0]   remainder,
  output unit_stat_t                stat
);

  logic [STEP_W-1:0]  cnt;
  logic               done;
  logic [DIV_W-1:0]   dq;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] dsr;
  logic [COUNT_W:0]   trial;
  logic               ge;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, dq[DIV_W-1]} - {1'b0, dsr};
    ge    = !trial[COUNT_W];
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == STEP_W'(1)) && !start;
      if (start) begin
        cnt <= steps;
      end else if (cnt != '0) begin
        cnt <= cnt - STEP_W'(1);
      end
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (cnt != '0) begin
      dq  <= {dq[DIV_W-2:0], ge};
      rem <= ge ? trial[COUNT_W-1:0] : {rem[COUNT_W-2:0], dq[DIV_W-1]};
    end
  end

  assign quotient  = dq;
  assign remainder = rem;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

`default_nettype wire

@@ design/rmv_sqr.sv @@
// ----------------------------------------------------------------------------
// rmv_sqr
// Shift-and-add squarer, one multiplier bit per cycle, msb first.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_sqr
  import rmv_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [SAMPLE_W-1:0] operand,
  output logic      [SQR_W-1:0]    product,
  output unit_stat_t               stat
);

  localparam int CNT_W = $clog2(SAMPLE_W + 1);

  logic [CNT_W-1:0]    cnt;
  logic                done;
  logic [SAMPLE_W-1:0] mcand;
  logic [SAMPLE_W-1:0] mplier;
  logic [SQR_W-1:0]    acc;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1)) && !start;
      if (start) begin
        cnt <= CNT_W'(SAMPLE_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // accumulate one partial product per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= operand;
      mplier <= operand;
      acc    <= '0;
    end else if (cnt != '0) begin
      acc    <= {acc[SQR_W-2:0], 1'b0}
                + (mplier[SAMPLE_W-1] ? {{(SQR_W-SAMPLE_W){1'b0}}, mcand} : '0);
      mplier <= {mplier[SAMPLE_W-2:0], 1'b0};
    end
  end

  assign product   = acc;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

`default_nettype wire

@@ design/rmv_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmv_sqrt
// Restoring integer square root, two radicand bits and one root bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_sqrt
  import rmv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [SQRT_W-1:0]  radicand,
  output logic      [SIGMA_W-1:0] root,
  output unit_stat_t              stat
);

  localparam int CNT_W = $clog2(SIGMA_W + 1);
  localparam int REM_W = SIGMA_W + 1;

  logic [CNT_W-1:0]   cnt;
  logic               done;
  logic [SQRT_W-1:0]  rad;
  logic [REM_W-1:0]   rem;
  logic [SIGMA_W-1:0] rt;
  logic [REM_W+1:0]   rem_sh;
  logic [REM_W+1:0]   trial;

  // trial subtract of 4*root+1
  always_comb begin
    rem_sh = {rem, rad[SQRT_W-1:SQRT_W-2]};
    trial  = rem_sh - {1'b0, rt, 2'b01};
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1)) && !start;
      if (start) begin
        cnt <= CNT_W'(SIGMA_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // root and remainder shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      rt  <= '0;
    end else if (cnt != '0) begin
      rad <= {rad[SQRT_W-3:0], 2'b00};
      if (!trial[REM_W+1]) begin
        rem <= trial[REM_W-1:0];
        rt  <= {rt[SIGMA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[REM_W-1:0];
        rt  <= {rt[SIGMA_W-2:0], 1'b0};
      end
    end
  end

  assign root      = rt;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the running mean / variance block: a local
// Welford model predicts every result beat and a scoreboard checks it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import rmv_pkg::*;

  // ordered msb first to match {m_tdata[174:0], m_tuser}
  typedef struct packed {
    logic [31:0] sigma;
    logic [47:0] variance;
    logic [30:0] abs_mean;
    logic [31:0] mean;
    logic [31:0] count;
    logic        skipped;
    logic        var_valid;
  } stats_t;

  // scoreboard with its own copy of the statistics
  class stats_board;
    bit          skip_on;
    logic [31:0] marker;
    logic [31:0] n;
    longint      mean;
    longint      abs_mean;
    logic [63:0] sq_sum;
    stats_t      pending[$];
    int          errors;

    function void clear();
      n = 0; mean = 0; abs_mean = 0; sq_sum = 0;
    endfunction

    function longint abs_sat(longint x);
      longint a;
      a = (x < 0) ? -x : x;
      return (a > 64'sh7FFFFFFF) ? 64'sh7FFFFFFF : a;
    endfunction

    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] r, b;
      r = 0; b = 64'h1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // apply one accepted sample and queue the expected beat
    function void note_sample(logic [31:0] xs, bit restart);
      stats_t      e;
      longint      x, d;
      logic [63:0] ud, dd, q, inc, v;
      logic [127:0] sq;
      e = '0;
      x = longint'(signed'(xs));
      if (restart) clear();
      if (skip_on && xs == marker) begin
        e.skipped = 1'b1;
      end else begin
        if (n != 32'hFFFFFFFF) n = n + 1;
        if (n == 1) begin
          mean = x; abs_mean = abs_sat(x); sq_sum = 0;
        end else begin
          d = x - mean;
          ud = (d < 0) ? -d : d;
          sq = ud * ud;
          dd = (sq[127:80] != 0) ? 64'hFFFFFFFFFFFFFFFF : sq[79:16];
          q = dd / n;
          if (dd % n != 0) q = q + 1;
          inc = dd - q;
          sq_sum = (sq_sum > ~inc) ? 64'hFFFFFFFFFFFFFFFF : sq_sum + inc;
          mean = mean + d / longint'(n);
          abs_mean = abs_mean + (abs_sat(x) - abs_mean) / longint'(n);
          abs_mean = abs_sat(abs_mean);
        end
      end
      if (n >= 2) begin
        v = sq_sum / (n - 1);
        if (v > 64'hFFFFFFFFFFFF) v = 64'hFFFFFFFFFFFF;
        e.variance = v[47:0];
        e.sigma = 32'(root64(v << 16));
        e.var_valid = 1'b1;
      end
      e.count = n;
      e.mean = mean[31:0];
      e.abs_mean = abs_mean[30:0];
      pending.push_back(e);
    endfunction

    function void check_beat(stats_t got);
      stats_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp cnt=%h mean=%h abs=%h var=%h sd=%h v=%b s=%b",
                   e.count, e.mean, e.abs_mean, e.variance, e.sigma, e.var_valid,
                   e.skipped, "\n          got cnt=%h mean=%h abs=%h var=%h sd=%h v=%b s=%b",
                   got.count, got.mean, got.abs_mean, got.variance, got.sigma,
                   got.var_valid, got.skipped);
      end
    endfunction
  endclass

  logic         clk, rst;
  logic         cfg_we, cfg_addr;
  logic [31:0]  cfg_wdata;
  logic         s_tvalid, s_tready, s_tuser;
  logic [31:0]  s_tdata;
  logic         m_tvalid, m_tready;
  logic [175:0] m_tdata;
  logic [1:0]   m_tuser;

  stats_board   board;
  bit           hold_sink;
  int           idle_cycles;

  running_mean_variance_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // register write while idle
  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SKIP_MISSING) board.skip_on = val[0];
    else board.marker = val;
    @(posedge clk);
  endtask

  // offer one sample beat after a random gap
  task automatic send_sample(logic [31:0] x, bit restart, int gap);
    // valid goes low after the previous beat before the next is offered
    repeat (gap + 1) @(posedge clk);
    s_tvalid <= 1'b1; s_tdata <= x; s_tuser <= restart;
    do @(posedge clk); while (!s_tready);
    board.note_sample(x, restart);
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      2: return board.marker;
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
    endcase
  endfunction

  // result side: random ready, one long hold-off
  initial begin
    int w;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        board.check_beat({m_tdata[174:0], m_tuser});
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        if (w != 0) begin
          m_tready <= 1'b0;
          repeat (w) @(posedge clk);
        end
      end
      m_tready <= !hold_sink;
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_sink)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] directed [0:11];
    int          mode;
    board = new();
    board.clear();
    board.skip_on = 0; board.marker = 0; board.errors = 0;
    hold_sink = 0;
    rst = 1'b1; cfg_we = 1'b0; cfg_addr = 1'b0; cfg_wdata = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, most negative sample, first-sample and restart cases
    directed = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h80000000,
                 32'h7FFFFFFF, 32'h00010000, 32'hFFFF0000, 32'h80000000,
                 32'h12345678, 32'h0, 32'h7FFFFFFF};
    for (int i = 0; i < 12; i++) send_sample(directed[i], i == 0 || i == 8, 0);
    drain();
    // skipping on, marker extremes, restart on a skipped sample
    write_reg(CFG_SKIP_MISSING, 32'h1);
    write_reg(CFG_MISSING_MARKER, 32'h80000000);
    send_sample(32'h80000000, 1, 0);
    send_sample(32'h80000000, 0, 1);
    send_sample(32'h7FFFFFFF, 0, 0);
    drain();
    write_reg(CFG_MISSING_MARKER, 32'h7FFFFFFF);
    send_sample(32'h7FFFFFFF, 0, 0);
    send_sample(32'h80000000, 0, 2);
    drain();

    // random phases with several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_SKIP_MISSING, ph % 2);
      write_reg(CFG_MISSING_MARKER, (ph == 4) ? 32'h0 : $urandom());
      for (int i = 0; i < 150; i++) begin
        if (ph == 2 && i == 40) begin
          hold_sink = 1;
          fork
            begin repeat (2000) @(posedge clk); hold_sink = 0; end
          join_none
        end
        if (ph == 3 && i == 75) while (board.pending.size() != 0) @(posedge clk);
        mode = $urandom_range(0, 9);
        mode = (mode < 2) ? 0 : (mode < 6) ? 1 : (mode < 7) ? 2 : 3;
        send_sample(rand_sample(mode), $urandom_range(0, 29) == 0,
                    ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
